/* rtl/fp64nc_pkg.sv */
// Format constants shared by the binary64 narrowing converter.
// No dependencies; imported by fp64nc_narrow and fp64_narrowing_converter.
package fp64nc_pkg;

  // binary64 source layout
  localparam int DBL_W      = 64;
  localparam int DBL_EXP_W  = 11;
  localparam int DBL_FRAC_W = 52;
  localparam int DBL_BIAS   = 1023;
  localparam int DBL_SIG_W  = DBL_FRAC_W + 1;
  localparam int SHIFT_W    = 6;

  // narrow target layouts
  localparam int SGL_EXP_W  = 8;
  localparam int SGL_FRAC_W = 23;
  localparam int SGL_W      = 1 + SGL_EXP_W + SGL_FRAC_W;

  localparam int HALF_EXP_W  = 5;
  localparam int HALF_FRAC_W = 10;
  localparam int HALF_W      = 1 + HALF_EXP_W + HALF_FRAC_W;

  localparam int BF_EXP_W  = 8;
  localparam int BF_FRAC_W = 7;
  localparam int BF_W      = 1 + BF_EXP_W + BF_FRAC_W;

  // largest right shift taken on the subnormal path; larger shifts always round to zero
  localparam int MAX_SUB_SHIFT = DBL_SIG_W + 1;

endpackage

/* rtl/fp64_narrowing_converter.sv */
// Top level of the binary64 narrowing converter: input register, three format
// converters (fp64nc_narrow) and a result register. Uses fp64nc_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall / in_double_bits carries one binary64
//   pattern per request. Result channel: out_valid / out_stall carries the
//   binary32, binary16 and bfloat16 encodings of that pattern together.
//   A request is taken on a rising edge with valid high and stall low.
//   A request passes from the input register through the conversion logic
//   into the result register, which drives the result ports.
//   Throughput: one request per cycle while out_stall is low; the conversion
//   logic between the registers has no state, so back-to-back requests never
//   wait on each other. When the receiver stalls, the result register holds
//   its value and the input register keeps filling; in_stall rises only when
//   both hold a request and the result is not being taken.
//   Reset (rst_n low, synchronous) empties both registers; no results are
//   pending afterwards. There is no configuration.
module fp64_narrowing_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fp64nc_pkg::DBL_W-1:0]    in_double_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fp64nc_pkg::SGL_W-1:0]    out_single_bits,
  output logic [fp64nc_pkg::HALF_W-1:0]   out_half_bits,
  output logic [fp64nc_pkg::BF_W-1:0]     out_brain_bits
);
  import fp64nc_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [DBL_W-1:0]  s1_bits_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SGL_W-1:0]  single_r;
  logic [HALF_W-1:0] half_r;
  logic [BF_W-1:0]   brain_r;
  logic [SGL_W-1:0]  single_c;
  logic [HALF_W-1:0] half_c;
  logic [BF_W-1:0]   brain_c;
  logic              out_adv;
  logic              s1_adv;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  always_comb begin
    s1_valid_nxt  = s1_adv ? in_valid : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_bits_r <= in_double_bits;
    end
    if (out_adv && s1_valid_r) begin
      single_r <= single_c;
      half_r   <= half_c;
      brain_r  <= brain_c;
    end
  end

  fp64nc_narrow #(.EXP_W(SGL_EXP_W), .FRAC_W(SGL_FRAC_W)) u_single (
    .dbl_bits (s1_bits_r),
    .nar_bits (single_c)
  );

  fp64nc_narrow #(.EXP_W(HALF_EXP_W), .FRAC_W(HALF_FRAC_W)) u_half (
    .dbl_bits (s1_bits_r),
    .nar_bits (half_c)
  );

  fp64nc_narrow #(.EXP_W(BF_EXP_W), .FRAC_W(BF_FRAC_W)) u_brain (
    .dbl_bits (s1_bits_r),
    .nar_bits (brain_c)
  );

  assign out_valid       = out_valid_r;
  assign out_single_bits = single_r;
  assign out_half_bits   = half_r;
  assign out_brain_bits  = brain_r;

`ifndef NO_ASSERTIONS
  // stall only with a request parked in the input register
  a_stall_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with empty input register");

  // a staged request moves into the result register when it is free
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("staged request lost on its way to the result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("registers not empty after reset");

  // all three encodings carry the same sign
  a_sign_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (single_r[SGL_W-1] == half_r[HALF_W-1]) &&
                    (single_r[SGL_W-1] == brain_r[BF_W-1]))
    else $error("sign differs across result formats");

  // NaN in one format means NaN in all formats
  a_nan_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((single_r[SGL_W-2:0] > {{SGL_EXP_W{1'b1}}, {SGL_FRAC_W{1'b0}}}) ==
                     (half_r[HALF_W-2:0] > {{HALF_EXP_W{1'b1}}, {HALF_FRAC_W{1'b0}}})) &&
                    ((single_r[SGL_W-2:0] > {{SGL_EXP_W{1'b1}}, {SGL_FRAC_W{1'b0}}}) ==
                     (brain_r[BF_W-2:0] > {{BF_EXP_W{1'b1}}, {BF_FRAC_W{1'b0}}})))
    else $error("NaN not consistent across result formats");
`endif

endmodule

/* rtl/fp64nc_narrow.sv */
// Combinational binary64 -> narrow IEEE format converter, round to nearest even.
// Depends on fp64nc_pkg for the binary64 layout.
module fp64nc_narrow #(
  parameter int EXP_W  = 8,
  parameter int FRAC_W = 23
) (
  input  logic [fp64nc_pkg::DBL_W-1:0] dbl_bits,
  output logic [EXP_W+FRAC_W:0]        nar_bits
);
  import fp64nc_pkg::*;

  localparam int Bias        = 2 ** (EXP_W - 1) - 1;
  localparam int NormShift   = DBL_FRAC_W - FRAC_W;
  localparam int MaxDexp     = DBL_BIAS + Bias;
  localparam int MinNormDexp = DBL_BIAS + 1 - Bias;
  // subnormal shift = SubBase - dexp
  localparam int SubBase     = DBL_FRAC_W - FRAC_W + 1 - Bias + DBL_BIAS;
  localparam int MinSubDexp  = SubBase - MAX_SUB_SHIFT;
  localparam int MagW        = EXP_W + FRAC_W;

  localparam logic [MagW-1:0] InfMag = {{EXP_W{1'b1}}, {FRAC_W{1'b0}}};
  localparam logic [MagW-1:0] NanMag = {{EXP_W{1'b1}}, 1'b1, {(FRAC_W-1){1'b0}}};

  // Shift right by sh (>= 1), rounding to nearest even on guard and the bits below it.
  function automatic logic [DBL_SIG_W-1:0] rne_shift(input logic [DBL_SIG_W-1:0] sig,
                                                     input logic [SHIFT_W-1:0]   sh);
    logic [DBL_SIG_W-1:0] q;
    logic [DBL_SIG_W-1:0] below;
    logic                 guard;
    logic                 up;
    q     = sig >> sh;
    guard = |((sig >> (sh - SHIFT_W'(1))) & DBL_SIG_W'(1));
    below = sig & ((DBL_SIG_W'(1) << (sh - SHIFT_W'(1))) - DBL_SIG_W'(1));
    up    = guard && ((below != '0) || q[0]);
    return q + DBL_SIG_W'(up);
  endfunction

  logic                       sign;
  logic [DBL_EXP_W-1:0]       dexp;
  logic [DBL_FRAC_W-1:0]      frac;
  logic [DBL_SIG_W-1:0]       sig;
  logic [DBL_SIG_W-1:0]       norm_rnd;
  logic [DBL_SIG_W-1:0]       sub_rnd;
  logic [EXP_W-1:0]           exp_m1;
  logic [MagW:0]              norm_sum;
  logic [DBL_EXP_W:0]         sub_sh_full;
  logic [SHIFT_W-1:0]         sub_sh;
  logic [MagW-1:0]            mag;

  assign sign = dbl_bits[DBL_W-1];
  assign dexp = dbl_bits[DBL_W-2 -: DBL_EXP_W];
  assign frac = dbl_bits[DBL_FRAC_W-1:0];
  assign sig  = {1'b1, frac};

  // Normal range: hidden bit rides along, so a rounding carry bumps the exponent.
  assign exp_m1   = EXP_W'(dexp - DBL_EXP_W'(MinNormDexp));
  assign norm_rnd = rne_shift(sig, SHIFT_W'(NormShift));
  assign norm_sum = {1'b0, exp_m1, {FRAC_W{1'b0}}} + (MagW+1)'(norm_rnd);

  assign sub_sh_full = (DBL_EXP_W+1)'(SubBase) - {1'b0, dexp};
  assign sub_sh      = sub_sh_full[SHIFT_W-1:0];
  assign sub_rnd     = rne_shift(sig, sub_sh);

  always_comb begin
    if (dexp == '1) begin
      mag = (frac != '0) ? NanMag : InfMag;
    end else if (dexp == '0) begin
      mag = '0;
    end else if (dexp > DBL_EXP_W'(MaxDexp)) begin
      mag = InfMag;
    end else if (dexp >= DBL_EXP_W'(MinNormDexp)) begin
      mag = (norm_sum > {1'b0, InfMag}) ? InfMag : norm_sum[MagW-1:0];
    end else if (dexp >= DBL_EXP_W'(MinSubDexp)) begin
      mag = sub_rnd[MagW-1:0];
    end else begin
      mag = '0;
    end
  end

  assign nar_bits = {sign, mag};

endmodule
